FILE: design/sbhm_pkg.sv
// shared types and constants of the spi burst handshake master
// used by every module of the block; no dependencies
package sbhm_pkg;

	localparam int PayloadLen  = 15;
	localparam int PayloadBits = PayloadLen * 8;
	localparam int IdxW        = 4;
	localparam int QueueDepth  = 2;

	localparam logic [7:0] RetryReset = 8'd17;
	localparam logic [7:0] ChStart    = 8'h73;
	localparam logic [7:0] ChAck      = 8'h61;
	localparam logic [7:0] ChEnd      = 8'h7a;
	localparam logic [7:0] ChEndAck   = 8'h5a;
	localparam logic [7:0] ChDummy    = 8'h00;
	localparam logic [7:0] AttemptMax = 8'hff;

	localparam logic RegRetryLimit = 1'b0;

	typedef enum logic {
		OP_START = 1'b0,
		OP_RX    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_ACK = 2'd1,
		ST_BAD_END = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_HS_START = 3'd1,
		PH_HS_DUMMY = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_END      = 3'd4
	} phase_t;

	typedef struct packed {
		logic                   start;
		logic [7:0]             rx;
		logic [PayloadBits-1:0] payload;
	} entry_t;

	typedef struct packed {
		logic [31:0] error_count;
		logic [31:0] got_word_three;
		logic [31:0] got_word_two;
		logic [31:0] got_word_one;
		logic [7:0]  got_throttle;
		logic [7:0]  got_turn;
		logic [7:0]  got_command;
		logic [1:0]  status;
		logic        done_res;
		logic [7:0]  tx_byte;
		logic        tx_valid;
	} result_t;

endpackage

FILE: design/sbhm_front.sv
// front stage: accepts input items, classifies start versus received byte
// and packs the payload bytes; depends on sbhm_pkg
module sbhm_front
	import sbhm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [127:0] in_data,
	input  logic         in_op,
	output logic         push_valid,
	input  logic         push_ready,
	output entry_t       push_entry
);

	logic   valid_s1;
	entry_t entry_s1;
	entry_t entry_d;

	always_comb begin
		entry_d = '0;
		entry_d.start = (op_t'(in_op) == OP_START);
		if (entry_d.start) begin
			entry_d.payload = in_data[PayloadBits-1:0];
		end else begin
			entry_d.rx = in_data[127:120];
		end
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

FILE: design/sbhm_queue.sv
// short queue between the front and back parts
// depends on sbhm_pkg for the entry type
module sbhm_queue
	import sbhm_pkg::*;
#(
	parameter int Depth = QueueDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  entry_t wr_entry,
	output logic   rd_valid,
	input  logic   rd_ready,
	output entry_t rd_entry
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	entry_t          slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign wr_ready = (count_q != CntW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

FILE: design/sbhm_back.sv
// back part: burst sequencer, reply staging and commit, output register
// depends on sbhm_pkg
module sbhm_back
	import sbhm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] retry_limit,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  entry_t     pop_entry,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_result
);

	phase_t          phase_q;
	phase_t          phase_d;
	logic [7:0]      attempt_q;
	logic [7:0]      attempt_d;
	logic [IdxW-1:0] idx_q;
	logic [IdxW-1:0] idx_d;
	logic [IdxW-1:0] idx_nxt;
	logic [7:0]      sendbuf_q   [PayloadLen];
	logic [7:0]      staged_q    [PayloadLen];
	logic [7:0]      committed_q [PayloadLen];
	logic [31:0]     mismatch_q;
	logic            out_valid_q;
	result_t         result_q;

	logic            step;
	logic            tx_valid;
	logic [7:0]      tx_byte;
	logic            done;
	status_t         status;
	logic            stage_we;
	logic            commit;
	logic            mis_inc;
	logic [7:0]      got [PayloadLen];
	logic [31:0]     err_d;

	assign pop_ready  = !out_valid_q || out_ready;
	assign step       = pop_valid && pop_ready;
	assign out_valid  = out_valid_q;
	assign out_result = result_q;
	assign idx_nxt    = idx_q + 1'b1;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (pop_entry.start) begin
			phase_d = PH_HS_START;
		end else begin
			unique case (phase_q)
				PH_HS_START: phase_d = PH_HS_DUMMY;
				PH_HS_DUMMY: begin
					if (attempt_q > retry_limit) begin
						phase_d = PH_IDLE;
					end else if (pop_entry.rx == ChAck) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_HS_START;
					end
				end
				PH_PAYLOAD: begin
					if (idx_nxt >= IdxW'(PayloadLen)) begin
						phase_d = PH_END;
					end
				end
				PH_END:  phase_d = PH_IDLE;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// step outputs and datapath controls
	always_comb begin
		tx_valid  = 1'b0;
		tx_byte   = '0;
		done      = 1'b0;
		status    = ST_OK;
		stage_we  = 1'b0;
		commit    = 1'b0;
		mis_inc   = 1'b0;
		attempt_d = attempt_q;
		idx_d     = idx_q;
		if (pop_entry.start) begin
			attempt_d = '0;
			idx_d     = '0;
			tx_valid  = 1'b1;
			tx_byte   = ChStart;
		end else begin
			unique case (phase_q)
				PH_HS_START: begin
					tx_valid = 1'b1;
					tx_byte  = ChDummy;
				end
				PH_HS_DUMMY: begin
					if (attempt_q > retry_limit) begin
						done   = 1'b1;
						status = ST_NO_ACK;
					end else begin
						if (attempt_q != AttemptMax) begin
							attempt_d = attempt_q + 1'b1;
						end
						tx_valid = 1'b1;
						if (pop_entry.rx == ChAck) begin
							idx_d   = '0;
							tx_byte = sendbuf_q[0];
						end else begin
							tx_byte = ChStart;
						end
					end
				end
				PH_PAYLOAD: begin
					stage_we = (idx_q < IdxW'(PayloadLen));
					idx_d    = idx_nxt;
					tx_valid = 1'b1;
					if (idx_nxt < IdxW'(PayloadLen)) begin
						tx_byte = sendbuf_q[idx_nxt];
					end else begin
						tx_byte = ChEnd;
					end
				end
				PH_END: begin
					done = 1'b1;
					if (pop_entry.rx == ChEndAck) begin
						commit = 1'b1;
					end else begin
						mis_inc = 1'b1;
						status  = ST_BAD_END;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < PayloadLen; i++) begin
			got[i] = commit ? staged_q[i] : committed_q[i];
		end
	end

	assign err_d = mismatch_q + {31'd0, mis_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			attempt_q   <= '0;
			idx_q       <= '0;
			mismatch_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PayloadLen; i++) begin
				staged_q[i]    <= '0;
				committed_q[i] <= '0;
			end
		end else begin
			if (pop_ready) begin
				out_valid_q <= pop_valid;
			end
			if (step) begin
				phase_q    <= phase_d;
				attempt_q  <= attempt_d;
				idx_q      <= idx_d;
				mismatch_q <= err_d;
				for (int i = 0; i < PayloadLen; i++) begin
					committed_q[i] <= got[i];
					if (pop_entry.start) begin
						staged_q[i] <= '0;
					end
				end
				if (stage_we) begin
					staged_q[idx_q] <= pop_entry.rx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (pop_entry.start) begin
				for (int i = 0; i < PayloadLen; i++) begin
					sendbuf_q[i] <= pop_entry.payload[i*8 +: 8];
				end
			end
			result_q.tx_valid       <= tx_valid;
			result_q.tx_byte        <= tx_byte;
			result_q.done_res       <= done;
			result_q.status         <= status;
			result_q.got_command    <= got[0];
			result_q.got_turn       <= got[1];
			result_q.got_throttle   <= got[2];
			result_q.got_word_one   <= {got[6], got[5], got[4], got[3]};
			result_q.got_word_two   <= {got[10], got[9], got[8], got[7]};
			result_q.got_word_three <= {got[14], got[13], got[12], got[11]};
			result_q.error_count    <= err_d;
		end
	end

endmodule

FILE: design/spi_burst_handshake_master_unit.sv
// top level of the spi burst handshake master
// joins sbhm_front, sbhm_queue and sbhm_back; holds the apb register
//
// usage: each input item on the s_axis channel is either a start (tuser 0)
// carrying the burst payload, or a byte received from the slave (tuser 1).
// every accepted item produces exactly one result item on m_axis with the
// next byte to send, the end-of-burst flag and status, the committed reply
// fields and the end marker error count.
// path: the accepting edge loads the front register, then the queue slot is
// written and then the back output register is loaded, after which the
// result is presented on m_axis.
// throughput: one item per cycle while m_axis_tready is high; the sequencer
// settles each step combinationally and the two-entry queue lets front and
// back stall independently. when m_axis_tready is low the output register
// holds its result, the queue fills and then s_axis_tready drops.
// reset clears the sequencer to idle, all reply stores and the error count
// to zero, retry_limit to 17. the user writes retry_limit, byte address 0,
// over apb only while no item is in flight; the block does not enforce it.
module spi_burst_handshake_master_unit
	import sbhm_pkg::*;
#(
	parameter int QDepth = QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command_byte, turn_velocity, forward_throttle, param_one, param_two,
	// param_three, rx_byte
	input  logic [127:0] s_axis_tdata,
	// operation
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tx_valid, tx_byte, done_res, status, got_command, got_turn, got_throttle,
	// got_word_one, got_word_two, got_word_three, error_count, zero pad
	output logic [167:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [7:0] retry_limit_q;
	logic       push_valid;
	logic       push_ready;
	entry_t     push_entry;
	logic       pop_valid;
	logic       pop_ready;
	entry_t     pop_entry;
	result_t    result;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegRetryLimit) ? {24'd0, retry_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RetryReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == RegRetryLimit) begin
			retry_limit_q <= pwdata[7:0];
		end
	end

	sbhm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_op      (s_axis_tuser[0]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	sbhm_queue #(
		.Depth (QDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_entry (pop_entry)
	);

	sbhm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.retry_limit (retry_limit_q),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_entry   (pop_entry),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_result  (result)
	);

	assign m_axis_tdata = {4'd0, result};

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result.status != 2'd3))
		else $error("status code out of range");

	a_status_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.status != ST_OK) |-> result.done_res)
		else $error("failure status without end of burst");

	a_done_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.done_res) |-> !result.tx_valid)
		else $error("byte to send at end of burst");

	a_start_sends_s: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready && pop_entry.start) |=>
			(m_axis_tvalid && result.tx_valid && result.tx_byte == ChStart))
		else $error("start item did not send the start byte");

endmodule

FILE: dv/spi_burst_handshake_master_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for spi_burst_handshake_master_unit: drives bursts and stray bytes
// on s_axis, predicts every m_axis result and compares it field by field
// depends on sbhm_pkg and the unit's rtl
module spi_burst_handshake_master_unit_tb;
	import sbhm_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles = 300;
	localparam int MaxReports = 40;
	localparam logic [2:0] AddrRetryLimit = {RegRetryLimit, 2'b00};

	typedef struct packed {
		logic [7:0]  rx;
		logic [31:0] param_three;
		logic [31:0] param_two;
		logic [31:0] param_one;
		logic [7:0]  throttle;
		logic [7:0]  turn;
		logic [7:0]  command;
	} burst_item_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [0:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [167:0] m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// sequencer copy
	phase_t       seq_phase = PH_IDLE;
	logic [7:0]   seq_attempts = '0;
	logic [3:0]   seq_index = '0;
	logic [119:0] tx_payload = '0;
	logic [119:0] reply_stage = '0;
	logic [119:0] reply_commit = '0;
	logic [31:0]  end_mismatches = '0;
	logic [7:0]   retry_limit_model = RetryReset;

	result_t results_due[$];
	result_t seen_result;
	result_t want_result;
	int failures = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	spi_burst_handshake_master_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic result_t advance_sequencer(input op_t op, input burst_item_t it);
		result_t r;
		r = '0;
		r.status = ST_OK;
		if (op == OP_START) begin
			tx_payload = {it.param_three, it.param_two, it.param_one, it.throttle, it.turn,
				it.command};
			reply_stage = '0;
			seq_attempts = '0;
			seq_index = '0;
			seq_phase = PH_HS_START;
			r.tx_valid = 1'b1;
			r.tx_byte = ChStart;
		end else begin
			case (seq_phase)
				PH_HS_START: begin
					seq_phase = PH_HS_DUMMY;
					r.tx_valid = 1'b1;
					r.tx_byte = ChDummy;
				end
				PH_HS_DUMMY: begin
					if (seq_attempts > retry_limit_model) begin
						seq_phase = PH_IDLE;
						r.done_res = 1'b1;
						r.status = ST_NO_ACK;
					end else begin
						if (seq_attempts != AttemptMax)
							seq_attempts = seq_attempts + 8'd1;
						r.tx_valid = 1'b1;
						if (it.rx == ChAck) begin
							seq_phase = PH_PAYLOAD;
							seq_index = '0;
							r.tx_byte = tx_payload[7:0];
						end else begin
							seq_phase = PH_HS_START;
							r.tx_byte = ChStart;
						end
					end
				end
				PH_PAYLOAD: begin
					if (seq_index < PayloadLen)
						reply_stage[8*seq_index +: 8] = it.rx;
					seq_index = seq_index + 4'd1;
					r.tx_valid = 1'b1;
					if (seq_index < PayloadLen) begin
						r.tx_byte = tx_payload[8*seq_index +: 8];
					end else begin
						seq_phase = PH_END;
						r.tx_byte = ChEnd;
					end
				end
				PH_END: begin
					seq_phase = PH_IDLE;
					r.done_res = 1'b1;
					if (it.rx == ChEndAck) begin
						reply_commit = reply_stage;
					end else begin
						end_mismatches = end_mismatches + 32'd1;
						r.status = ST_BAD_END;
					end
				end
				default: seq_phase = PH_IDLE;
			endcase
		end
		r.got_command = reply_commit[7:0];
		r.got_turn = reply_commit[15:8];
		r.got_throttle = reply_commit[23:16];
		r.got_word_one = reply_commit[55:24];
		r.got_word_two = reply_commit[87:56];
		r.got_word_three = reply_commit[119:88];
		r.error_count = end_mismatches;
		return r;
	endfunction

	function automatic logic [7:0] reply_byte();
		case ($urandom_range(9))
			0: return ChAck;
			1: return ChEndAck;
			2: return ChStart;
			3: return ChEnd;
			4: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] reply_except(input logic [7:0] avoid);
		logic [7:0] b;
		do b = reply_byte(); while (b == avoid);
		return b;
	endfunction

	function automatic logic [31:0] param_word();
		case ($urandom_range(11))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic burst_item_t burst_fields();
		burst_item_t it;
		it = {$urandom, $urandom, $urandom, $urandom};
		it.param_one = param_word();
		it.param_two = param_word();
		it.param_three = param_word();
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_item(input op_t op, input burst_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		results_due.push_back(advance_sequencer(op, it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_reply(input logic [7:0] rx);
		burst_item_t it;
		it = {$urandom, $urandom, $urandom, $urandom};
		it.rx = rx;
		push_item(OP_RX, it);
	endtask

	task automatic await_idle();
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_retry_limit(input logic [7:0] value);
		logic [31:0] readback;
		await_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrRetryLimit;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		retry_limit_model = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== {24'd0, value}) begin
			failures++;
			$display("%0t mismatch retry_limit readback: expected %0h, got %0h", $time,
				{24'd0, value}, readback);
		end
	endtask

	// a burst that gives up after cut items, or when the sequencer falls idle
	task automatic run_burst(input burst_item_t fields, input int fails, input bit end_ok,
			input int cut);
		int n;
		n = 1;
		push_item(OP_START, fields);
		for (int a = 0; a <= fails; a++) begin
			if (n >= cut)
				return;
			send_reply(reply_byte());
			n++;
			if (n >= cut)
				return;
			send_reply(a == fails ? ChAck : reply_except(ChAck));
			n++;
			if (seq_phase == PH_IDLE)
				return;
		end
		for (int i = 0; i < PayloadLen; i++) begin
			if (n >= cut)
				return;
			send_reply(reply_byte());
			n++;
		end
		if (n >= cut)
			return;
		send_reply(end_ok ? ChEndAck : reply_except(ChEndAck));
	endtask

	task automatic test_directed();
		burst_item_t edge_fields;
		edge_fields = '0;
		// stray byte while idle, then a burst cut short by a new start
		send_reply(ChAck);
		push_item(OP_START, '0);
		send_reply(8'hff);
		edge_fields.command = 8'hff;
		edge_fields.turn = 8'h80;
		edge_fields.throttle = 8'h7f;
		edge_fields.param_one = 32'h8000_0000;
		edge_fields.param_two = 32'h7fff_ffff;
		edge_fields.param_three = 32'hffff_ffff;
		edge_fields.rx = 8'hff;
		run_burst(edge_fields, 1, 1'b1, 1000);
	endtask

	task automatic test_retry_floor();
		write_retry_limit(8'd0);
		// second attempt aborts even though the slave answers with the ack
		run_burst(burst_fields(), 1, 1'b1, 1000);
		send_reply(ChEndAck);
	endtask

	task automatic test_attempt_saturation();
		write_retry_limit(8'hff);
		run_burst(burst_fields(), 257, 1'b1, 1000);
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		run_burst(burst_fields(), 1, 1'b1, 1000);
		run_burst(burst_fields(), 0, 1'b0, 1000);
	endtask

	task automatic test_random(input int count);
		int stop_at;
		int kind;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 8) begin
				repeat ($urandom_range(1, 3)) send_reply(reply_byte());
			end else if (kind < 18) begin
				run_burst(burst_fields(), $urandom_range(0, 2), 1'($urandom_range(1)),
					$urandom_range(1, 20));
			end else begin
				run_burst(burst_fields(),
					($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2),
					$urandom_range(99) < 85, 1000);
			end
		end
	endtask

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			failures++;
			if (failures <= MaxReports)
				$display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, seen);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result = m_axis_tdata[$bits(result_t)-1:0];
			if (results_due.size() == 0) begin
				failures++;
				if (failures <= MaxReports)
					$display("%0t unexpected result: expected none, got %h", $time,
						seen_result);
			end else begin
				want_result = results_due.pop_front();
				flag_field("tx_valid", want_result.tx_valid, seen_result.tx_valid);
				flag_field("tx_byte", want_result.tx_byte, seen_result.tx_byte);
				flag_field("done_res", want_result.done_res, seen_result.done_res);
				flag_field("status", want_result.status, seen_result.status);
				flag_field("got_command", want_result.got_command, seen_result.got_command);
				flag_field("got_turn", want_result.got_turn, seen_result.got_turn);
				flag_field("got_throttle", want_result.got_throttle,
					seen_result.got_throttle);
				flag_field("got_word_one", want_result.got_word_one,
					seen_result.got_word_one);
				flag_field("got_word_two", want_result.got_word_two,
					seen_result.got_word_two);
				flag_field("got_word_three", want_result.got_word_three,
					seen_result.got_word_three);
				flag_field("error_count", want_result.error_count, seen_result.error_count);
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 83;
		test_directed();
		test_random(50);

		send_idle_pct = 83;
		recv_idle_pct = 11;
		test_retry_floor();
		test_random(50);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_attempt_saturation();
		test_backpressure();
		write_retry_limit(8'($urandom_range(1, 6)));
		test_random(50);

		await_idle();
		if (failures == 0 && results_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
